// ===== hdl/hex_endpoint_record_parser_core_macros.svh =====
// Assertion macros shared by the record parser modules.
`ifndef HEX_ENDPOINT_RECORD_PARSER_CORE_MACROS_SVH
`define HEX_ENDPOINT_RECORD_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define HRP_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);
// Checked property that also holds during reset.
`define HRP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define HRP_ASSERT(lbl, clk_sig, rstn_sig, prop, msg)
`define HRP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif
`endif

// ===== hdl/hrp_pkg.sv =====
// Types, constants and helper functions shared by the record parser modules.
package hrp_pkg;

  // Capability store size per record and derived widths.
  localparam int CAPS_MAX   = 32;
  localparam int CAPS_IDX_W = $clog2(CAPS_MAX);
  localparam int ADDR_W     = CAPS_IDX_W + 1;
  localparam int STORE_DEPTH = 2 * CAPS_MAX;
  localparam int CNT_W      = 6;
  localparam int DIG_W      = 7;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(32);
  localparam logic [7:0]       CHAR_COLON  = 8'h3A;

  // Write port of the capability store, driven by the parser.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // Summary of one finished record.
  typedef struct packed {
    logic             ok;
    logic [7:0]       type_byte;
    logic [7:0]       codec_byte;
    logic             dly_report;
    logic [CNT_W-1:0] caps_count;
  } rec_t;

  // Queue status seen by the parser.
  typedef struct packed {
    logic full;
    logic wr_bank;
  } q_stat_t;

  // Queue head seen by the emitter.
  typedef struct packed {
    logic valid;
    logic bank;
    rec_t rec;
  } q_head_t;

  // Hex digit decode: bit 4 set when the character is a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/hrp_front.sv =====
// Character parser: classifies characters, fills the capability store, queues record summaries.
`include "hex_endpoint_record_parser_core_macros.svh"
module hrp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] char_code
  input  logic                       in_tlast,   // is_final
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hrp_pkg::CNT_W-1:0]  cfg_data,   // caps_limit
  input  hrp_pkg::q_stat_t           q_stat,
  output logic                       push,
  output hrp_pkg::rec_t              push_rec,
  output hrp_pkg::store_wr_t         store_wr
);

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_TYPE_HI  = 3'd0;
  localparam logic [PH_W-1:0] PH_TYPE_LO  = 3'd1;
  localparam logic [PH_W-1:0] PH_COLON1   = 3'd2;
  localparam logic [PH_W-1:0] PH_CODEC_HI = 3'd3;
  localparam logic [PH_W-1:0] PH_CODEC_LO = 3'd4;
  localparam logic [PH_W-1:0] PH_COLON2   = 3'd5;
  localparam logic [PH_W-1:0] PH_OPT      = 3'd6;
  localparam logic [PH_W-1:0] PH_CAPS     = 3'd7;

  logic [hrp_pkg::CNT_W-1:0] limit_r;
  logic [PH_W-1:0]           phase_r, phase_nxt;
  logic [3:0]                hi_r, hi_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [7:0]                codec_r, codec_nxt;
  logic                      delay_r, delay_nxt;
  logic [7:0]                look_r, look_nxt;
  logic [hrp_pkg::DIG_W-1:0] digits_r, digits_nxt;
  logic                      err_r, err_nxt;

  logic                      accept;
  logic [4:0]                hex;
  logic                      add_dig;
  logic [hrp_pkg::DIG_W-1:0] dig_inc;
  logic [hrp_pkg::CNT_W-1:0] eff_limit;
  logic [hrp_pkg::CNT_W-1:0] idx_full;
  logic [7:0]                byte_val;
  logic                      wr_en;
  logic                      rec_ok;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && in_tlast;
  assign hex       = hrp_pkg::hex_decode(in_tdata);

  // Limit in force is the register clipped to the store size.
  assign eff_limit = (limit_r > hrp_pkg::CNT_W'(hrp_pkg::CAPS_MAX)) ?
                     hrp_pkg::CNT_W'(hrp_pkg::CAPS_MAX) : limit_r;

  assign dig_inc  = digits_r + hrp_pkg::DIG_W'(1);
  assign byte_val = {hi_r, hex[3:0]};
  assign idx_full = dig_inc[hrp_pkg::DIG_W-1:1] - hrp_pkg::CNT_W'(1);

  // Next parser state for the current character.
  always_comb begin
    phase_nxt  = phase_r;
    hi_nxt     = hi_r;
    type_nxt   = type_r;
    codec_nxt  = codec_r;
    delay_nxt  = delay_r;
    look_nxt   = look_r;
    digits_nxt = digits_r;
    err_nxt    = err_r;
    add_dig    = 1'b0;
    wr_en      = 1'b0;
    if (!err_r) begin
      case (phase_r)
        PH_TYPE_HI, PH_CODEC_HI: begin
          if (!hex[4]) begin
            err_nxt = 1'b1;
          end else begin
            hi_nxt    = hex[3:0];
            phase_nxt = phase_r + PH_W'(1);
          end
        end
        PH_TYPE_LO: begin
          if (!hex[4]) begin
            err_nxt = 1'b1;
          end else begin
            type_nxt  = byte_val;
            phase_nxt = phase_r + PH_W'(1);
          end
        end
        PH_CODEC_LO: begin
          if (!hex[4]) begin
            err_nxt = 1'b1;
          end else begin
            codec_nxt = byte_val;
            phase_nxt = phase_r + PH_W'(1);
          end
        end
        PH_COLON1, PH_COLON2: begin
          if (in_tdata != hrp_pkg::CHAR_COLON) begin
            err_nxt = 1'b1;
          end else begin
            phase_nxt = phase_r + PH_W'(1);
          end
        end
        PH_OPT: begin
          if (in_tdata == hrp_pkg::CHAR_COLON) begin
            // Two digits before a colon form the delay byte.
            if (digits_r != hrp_pkg::DIG_W'(2) || look_r > 8'd1) begin
              err_nxt = 1'b1;
            end else begin
              delay_nxt  = look_r[0];
              digits_nxt = '0;
              phase_nxt  = PH_CAPS;
            end
          end else if (!hex[4]) begin
            err_nxt = 1'b1;
          end else begin
            add_dig = 1'b1;
          end
        end
        PH_CAPS: begin
          if (!hex[4]) begin
            err_nxt = 1'b1;
          end else begin
            add_dig = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end

    // One capability digit: a pair of digits completes a stored byte.
    if (add_dig) begin
      digits_nxt = dig_inc;
      if (dig_inc > {eff_limit, 1'b0}) begin
        err_nxt = 1'b1;
      end else if (dig_inc[0]) begin
        hi_nxt = hex[3:0];
      end else begin
        wr_en = 1'b1;
        if (phase_r == PH_OPT && idx_full == '0) begin
          look_nxt = byte_val;
        end
      end
    end
  end

  // Record verdict from the state after the final character.
  assign rec_ok = !err_nxt && (phase_nxt == PH_OPT || phase_nxt == PH_CAPS) &&
                  digits_nxt != '0 && !digits_nxt[0] &&
                  digits_nxt[hrp_pkg::DIG_W-1:1] <= eff_limit;

  always_comb begin
    push_rec                 = '0;
    push_rec.ok              = rec_ok;
    if (rec_ok) begin
      push_rec.type_byte       = type_nxt;
      push_rec.codec_byte      = codec_nxt;
      push_rec.dly_report      = delay_nxt;
      push_rec.caps_count      = digits_nxt[hrp_pkg::DIG_W-1:1];
    end
  end

  assign store_wr.we   = accept && wr_en;
  assign store_wr.addr = {q_stat.wr_bank, idx_full[hrp_pkg::CAPS_IDX_W-1:0]};
  assign store_wr.data = byte_val;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= hrp_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // Parser state; a final character returns it to the start of a record.
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r  <= PH_TYPE_HI;
      hi_r     <= '0;
      type_r   <= '0;
      codec_r  <= '0;
      delay_r  <= 1'b0;
      look_r   <= '0;
      digits_r <= '0;
      err_r    <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      hi_r     <= hi_nxt;
      type_r   <= type_nxt;
      codec_r  <= codec_nxt;
      delay_r  <= delay_nxt;
      look_r   <= look_nxt;
      digits_r <= digits_nxt;
      err_r    <= err_nxt;
    end
  end

  `HRP_ASSERT(a_wr_no_err, clk, rst_n, store_wr.we |-> (accept && !err_r), "store write after error")

endmodule

// ===== hdl/hrp_queue.sv =====
// Two-entry queue of record summaries; each slot owns one store bank.
`include "hex_endpoint_record_parser_core_macros.svh"
module hrp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrp_pkg::rec_t     push_rec,
  input  logic              pop,
  output hrp_pkg::q_stat_t  q_stat,
  output hrp_pkg::q_head_t  q_head
);

  hrp_pkg::rec_t slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  assign q_stat.full    = (count_r == 2'd2);
  assign q_stat.wr_bank = wr_ptr_r;
  assign q_head.valid   = (count_r != 2'd0);
  assign q_head.bank    = rd_ptr_r;
  assign q_head.rec     = slot_r[rd_ptr_r];

  // Slot payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  `HRP_ASSERT(a_no_overflow, clk, rst_n, !(push && q_stat.full), "push into full queue")
  `HRP_ASSERT(a_no_underflow, clk, rst_n, !(pop && !q_head.valid), "pop from empty queue")

endmodule

// ===== hdl/hrp_back.sv =====
// Result emitter: turns queued records into summary and capability byte transactions.
`include "hex_endpoint_record_parser_core_macros.svh"
module hrp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hrp_pkg::store_wr_t  store_wr,
  input  hrp_pkg::q_head_t    q_head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  // Capability store: one bank per queue slot.
  logic [7:0] store_mem [hrp_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;

  logic [hrp_pkg::CNT_W-1:0] k_r;
  logic [hrp_pkg::CNT_W-1:0] k_dec;
  logic                      issue;
  logic                      is_last;
  logic                      s1_adv;
  logic [hrp_pkg::ADDR_W-1:0] rd_addr;

  // Read stage registers.
  logic          s1_valid_r;
  logic          s1_kind_r;
  logic          s1_last_r;
  hrp_pkg::rec_t s1_rec_r;

  // Output stage registers.
  logic          out_valid_r;
  logic          out_kind_r;
  logic          out_last_r;
  hrp_pkg::rec_t out_rec_r;
  logic [7:0]    out_byte_r;

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_tready);
  assign issue   = q_head.valid && (!s1_valid_r || s1_adv);
  assign is_last = (k_r == q_head.rec.caps_count);
  assign pop     = issue && is_last;
  assign k_dec   = k_r - hrp_pkg::CNT_W'(1);
  assign rd_addr = {q_head.bank, k_dec[hrp_pkg::CAPS_IDX_W-1:0]};

  // Store write from the parser and registered read for the emitter.
  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      store_mem[store_wr.addr] <= store_wr.data;
    end
    if (issue) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Item counter within the head record.
  always_ff @(posedge clk) begin
    if (!rst_n || pop) begin
      k_r <= '0;
    end else if (issue) begin
      k_r <= k_r + hrp_pkg::CNT_W'(1);
    end
  end

  // Read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r <= (k_r != '0);
      s1_last_r <= is_last;
      s1_rec_r  <= q_head.rec;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r <= s1_kind_r;
      out_last_r <= s1_last_r;
      out_rec_r  <= s1_rec_r;
      out_byte_r <= s1_kind_r ? rd_data_r : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_byte_r, out_rec_r.caps_count, out_rec_r.dly_report,
                       out_rec_r.codec_byte, out_rec_r.type_byte, out_rec_r.ok};

  `HRP_ASSERT(a_pop_last, clk, rst_n, pop |=> (s1_valid_r && s1_last_r), "pop without last item")
  `HRP_ASSERT(a_first_summary, clk, rst_n, (issue && k_r == '0) |=> !s1_kind_r, "record not opened by summary")

endmodule

// ===== hdl/hex_endpoint_record_parser_core.sv =====
// A record's summary passes through the record queue, the read stage and the output register before it leaves.
// Throughput: one character per cycle in; one result per cycle out while out_tready is held (count+1 per record).
// The input stalls only while two finished records wait in the record queue,
// each holding one bank of the two-bank capability store.
// Reset (rst_n, synchronous, active low) clears the parser, queue and output
// stages and sets caps_limit to 32; the capability store is not cleared.
module hex_endpoint_record_parser_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] char_code
  input  logic                      in_tlast,   // is_final
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // [0] valid_res, [8:1] type_byte,
                                                // [16:9] codec_byte, [17] dly_report,
                                                // [23:18] caps_count, [31:24] caps_byte
  output logic                      out_tuser,  // kind
  output logic                      out_tlast,  // last_of_run
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hrp_pkg::CNT_W-1:0] cfg_data    // caps_limit
);

  hrp_pkg::q_stat_t   q_stat;
  hrp_pkg::q_head_t   q_head;
  hrp_pkg::rec_t      push_rec;
  hrp_pkg::store_wr_t store_wr;
  logic               push;
  logic               pop;

  // Parser front end.
  hrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec),
    .store_wr  (store_wr)
  );

  // Record queue between parser and emitter.
  hrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .q_stat   (q_stat),
    .q_head   (q_head)
  );

  // Result emitter with the capability store.
  hrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .store_wr   (store_wr),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/hex_endpoint_record_parser_core_tb.sv =====
// Self-checking bench for the endpoint record parser against a built-in predictor.
module hex_endpoint_record_parser_core_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_CHARS   = 60;
  localparam int MAX_REPORTS    = 10;
  localparam int NO_DELAY       = -1;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_LOWER = 8'h61;
  localparam logic [7:0] ASCII_UPPER = 8'h41;
  localparam logic [7:0] ASCII_DASH  = 8'h2D;
  localparam logic [7:0] ASCII_G     = 8'h67;

  // Parser phases, in record order.
  typedef enum logic [3:0] {
    P_TYPE_HI, P_TYPE_LO, P_COLON1, P_CODEC_HI, P_CODEC_LO, P_COLON2, P_OPT, P_CAPS
  } parse_phase_t;

  // One result transaction, unpacked into its fields.
  typedef struct packed {
    logic                      kind;
    logic                      ok;
    logic [7:0]                type_b;
    logic [7:0]                codec_b;
    logic                      delay_flag;
    logic [hrp_pkg::CNT_W-1:0] count;
    logic [7:0]                cap;
    logic                      last;
  } result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata = 8'h00;
  logic                      in_tlast = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [31:0]               out_tdata;
  logic                      out_tuser;
  logic                      out_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [hrp_pkg::CNT_W-1:0] cfg_data = '0;

  // Predictor state.
  logic [hrp_pkg::CNT_W-1:0] limit_now;
  parse_phase_t              phase;
  logic [3:0]                hi_nib;
  logic [7:0]                type_r;
  logic [7:0]                codec_r;
  logic                      delay_r;
  logic [7:0]                look_byte;
  logic [7:0]                cap_bytes [hrp_pkg::CAPS_MAX];
  int                        cap_digits;
  logic                      parse_err;

  result_t    pending_results[$];
  logic [7:0] rec_buf[$];
  int         mismatch_count = 0;
  int         result_index = 0;
  int         chars_sent = 0;
  int         quiet_cycles = 0;
  int         hold_cycles = 0;
  bit         idle_enable = 1'b1;

  hex_endpoint_record_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  function automatic int active_limit();
    return (int'(limit_now) < hrp_pkg::CAPS_MAX) ? int'(limit_now) : hrp_pkg::CAPS_MAX;
  endfunction

  function automatic void clear_record();
    phase      = P_TYPE_HI;
    hi_nib     = 4'h0;
    type_r     = 8'h00;
    codec_r    = 8'h00;
    delay_r    = 1'b0;
    look_byte  = 8'h00;
    cap_digits = 0;
    parse_err  = 1'b0;
  endfunction

  // A digit of the capability string; the first byte doubles as the delay candidate.
  function automatic void add_cap_digit(input logic [3:0] v);
    int idx;
    logic [7:0] b;
    cap_digits++;
    if (cap_digits > 2 * active_limit()) begin
      parse_err = 1'b1;
      return;
    end
    if (cap_digits % 2 == 1) begin
      hi_nib = v;
      return;
    end
    b = {hi_nib, v};
    idx = cap_digits / 2 - 1;
    cap_bytes[idx] = b;
    if (phase == P_OPT && idx == 0) look_byte = b;
  endfunction

  // Advances the parser by one character and queues the results of a final one.
  function automatic void predict_char(input logic [7:0] c, input logic fin);
    int h;
    int n;
    logic ok;
    result_t r;
    h = hex_value(c);
    if (!parse_err) begin
      case (phase)
        P_TYPE_HI, P_CODEC_HI: begin
          if (h < 0) parse_err = 1'b1;
          else begin
            hi_nib = h[3:0];
            phase = (phase == P_TYPE_HI) ? P_TYPE_LO : P_CODEC_LO;
          end
        end
        P_TYPE_LO: begin
          if (h < 0) parse_err = 1'b1;
          else begin
            type_r = {hi_nib, h[3:0]};
            phase = P_COLON1;
          end
        end
        P_CODEC_LO: begin
          if (h < 0) parse_err = 1'b1;
          else begin
            codec_r = {hi_nib, h[3:0]};
            phase = P_COLON2;
          end
        end
        P_COLON1, P_COLON2: begin
          if (c != hrp_pkg::CHAR_COLON) parse_err = 1'b1;
          else phase = (phase == P_COLON1) ? P_CODEC_HI : P_OPT;
        end
        P_OPT: begin
          if (c == hrp_pkg::CHAR_COLON) begin
            if (cap_digits != 2 || look_byte > 8'd1) parse_err = 1'b1;
            else begin
              delay_r = look_byte[0];
              cap_digits = 0;
              phase = P_CAPS;
            end
          end else if (h < 0) parse_err = 1'b1;
          else add_cap_digit(h[3:0]);
        end
        P_CAPS: begin
          if (h < 0) parse_err = 1'b1;
          else add_cap_digit(h[3:0]);
        end
        default: parse_err = 1'b1;
      endcase
    end
    if (!fin) return;

    ok = !parse_err && (phase == P_OPT || phase == P_CAPS) && cap_digits != 0 &&
         cap_digits % 2 == 0 && cap_digits / 2 <= active_limit();
    n = ok ? cap_digits / 2 : 0;
    for (int k = 0; k <= n; k++) begin
      r.kind       = (k != 0);
      r.ok         = ok;
      r.type_b     = ok ? type_r : 8'h00;
      r.codec_b    = ok ? codec_r : 8'h00;
      r.delay_flag = ok ? delay_r : 1'b0;
      r.count      = hrp_pkg::CNT_W'(n);
      r.cap        = (k == 0) ? 8'h00 : cap_bytes[k-1];
      r.last       = (k == n);
      pending_results.push_back(r);
    end
    clear_record();
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string describe(input result_t r);
    return $sformatf("kind=%0d ok=%0d type=%h codec=%h delay=%0d count=%0d cap=%h last=%0d",
                     r.kind, r.ok, r.type_b, r.codec_b, r.delay_flag, r.count, r.cap, r.last);
  endfunction

  // Each output transaction is compared with the oldest pending result.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    string bad;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, ok: out_tdata[0], type_b: out_tdata[8:1],
              codec_b: out_tdata[16:9], delay_flag: out_tdata[17],
              count: out_tdata[23:18], cap: out_tdata[31:24], last: out_tlast};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d arrived with nothing pending: %s", result_index, describe(got));
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (got.kind !== want.kind) bad = {bad, " kind"};
        if (got.ok !== want.ok) bad = {bad, " valid_res"};
        if (got.type_b !== want.type_b) bad = {bad, " type_byte"};
        if (got.codec_b !== want.codec_b) bad = {bad, " codec_byte"};
        if (got.delay_flag !== want.delay_flag) bad = {bad, " dly_report"};
        if (got.count !== want.count) bad = {bad, " caps_count"};
        if (got.cap !== want.cap) bad = {bad, " caps_byte"};
        if (got.last !== want.last) bad = {bad, " last_of_run"};
        if (bad.len() != 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d mismatch in%s", result_index, bad);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
      result_index++;
    end
  end

  // The run ends if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls in short random bursts.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      hold_cycles = $urandom_range(0, 2);
    end else begin
      out_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_char(input logic [7:0] c, input logic fin);
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = fin;
    do @(posedge clk); while (!in_tready);
    predict_char(c, fin);
    chars_sent++;
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_buf.size(); i++)
      send_char(rec_buf[i], i == rec_buf.size() - 1);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Limit writes happen only with the parser idle and every result delivered.
  task automatic write_limit(input logic [hrp_pkg::CNT_W-1:0] value);
    idle_input();
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    limit_now = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------- record builders

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ASCII_ZERO + 8'(n);
    return ($urandom_range(0, 1) ? ASCII_LOWER : ASCII_UPPER) + 8'(n) - 8'd10;
  endfunction

  function automatic void push_hex_byte(input logic [7:0] b);
    rec_buf.push_back(hex_char(b[7:4]));
    rec_buf.push_back(hex_char(b[3:0]));
  endfunction

  // Well-formed record; delay_val of NO_DELAY leaves the delay field out.
  function automatic void build_record(input logic [7:0] type_b, input logic [7:0] codec_b,
                                       input int delay_val, input int ncaps);
    rec_buf.delete();
    push_hex_byte(type_b);
    rec_buf.push_back(hrp_pkg::CHAR_COLON);
    push_hex_byte(codec_b);
    rec_buf.push_back(hrp_pkg::CHAR_COLON);
    if (delay_val != NO_DELAY) begin
      push_hex_byte(8'(delay_val));
      rec_buf.push_back(hrp_pkg::CHAR_COLON);
    end
    repeat (ncaps) push_hex_byte(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------- tests

  // Field extremes and each kind of malformed record, at the reset limit.
  task automatic test_directed_records();
    build_record(8'h00, 8'h00, NO_DELAY, 1);
    send_record();
    build_record(8'hFF, 8'hFF, 1, 3);
    send_record();
    build_record(8'hA5, 8'h5A, 0, 2);
    send_record();
    // Delay byte above one.
    build_record(8'h12, 8'h34, 2, 2);
    send_record();
    // Delay field present but no capability string.
    build_record(8'hAA, 8'hBB, 1, 0);
    send_record();
    // Header only.
    build_record(8'hAA, 8'hBB, NO_DELAY, 0);
    send_record();
    // Two digits with no colon after them are a one-byte capability string.
    build_record(8'h3C, 8'hC3, NO_DELAY, 0);
    push_hex_byte(8'h01);
    send_record();
    // Odd number of capability digits.
    build_record(8'h01, 8'h02, NO_DELAY, 2);
    rec_buf.push_back(hex_char(4'hE));
    send_record();
    // Wrong separator after the type.
    build_record(8'h10, 8'h20, NO_DELAY, 2);
    rec_buf[2] = ASCII_DASH;
    send_record();
    // Character code zero in place of the second colon.
    build_record(8'h10, 8'h20, NO_DELAY, 2);
    rec_buf[5] = 8'h00;
    send_record();
    // All-ones character code in the type.
    build_record(8'h10, 8'h20, NO_DELAY, 2);
    rec_buf[0] = 8'hFF;
    send_record();
    // A colon deep in the capability string.
    build_record(8'h77, 8'h88, NO_DELAY, 3);
    rec_buf[10] = hrp_pkg::CHAR_COLON;
    send_record();
    // Three digits before a colon are not a delay byte.
    build_record(8'h12, 8'h34, NO_DELAY, 0);
    push_hex_byte(8'h12);
    rec_buf.push_back(hex_char(4'h3));
    rec_buf.push_back(hrp_pkg::CHAR_COLON);
    push_hex_byte(8'h45);
    send_record();
    // Non-hex letter in the capability string.
    build_record(8'h55, 8'h66, 0, 2);
    rec_buf[11] = ASCII_G;
    send_record();
    // Early error; the rest of the record is ignored.
    build_record(8'h55, 8'h66, 1, 4);
    rec_buf[0] = ASCII_G;
    send_record();
    // Truncated inside the codec.
    build_record(8'hAB, 8'hC0, NO_DELAY, 1);
    while (rec_buf.size() > 4) void'(rec_buf.pop_back());
    send_record();
    // One-character records.
    rec_buf.delete();
    rec_buf.push_back(hex_char(4'h5));
    send_record();
    rec_buf[0] = ASCII_G;
    send_record();
    // Capability string exactly at the limit.
    build_record(8'hC4, 8'h4C, NO_DELAY, hrp_pkg::CAPS_MAX);
    send_record();
  endtask

  // Smallest, zero and out-of-range limit settings.
  task automatic test_limit_extremes();
    write_limit(hrp_pkg::CNT_W'(1));
    build_record(8'h11, 8'h22, NO_DELAY, 1);
    send_record();
    build_record(8'h11, 8'h22, 0, 1);
    send_record();
    build_record(8'h11, 8'h22, NO_DELAY, 2);
    send_record();
    build_record(8'h11, 8'h22, 1, 2);
    send_record();
    write_limit(hrp_pkg::CNT_W'(0));
    build_record(8'h33, 8'h44, NO_DELAY, 1);
    send_record();
    build_record(8'h33, 8'h44, 0, 1);
    send_record();
    // A limit above the store size is clipped to it.
    write_limit('1);
    build_record(8'h99, 8'h66, 1, hrp_pkg::CAPS_MAX + 1);
    send_record();
  endtask

  // Mostly well-formed records with random content, plus damaged ones and noise.
  task automatic test_random_records();
    int sel;
    int ncaps;
    int delay_val;
    int nrec;
    bit paused;
    chars_sent = 0;
    nrec = 0;
    paused = 1'b0;
    idle_enable = 1'b1;
    while (chars_sent < RANDOM_CHARS) begin
      if (nrec % 8 == 0) write_limit(hrp_pkg::CNT_W'($urandom_range(1, hrp_pkg::CAPS_MAX)));
      if (!paused && chars_sent >= RANDOM_CHARS / 2) begin
        // Hold the input until every result so far is out.
        idle_input();
        wait_drained();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: delay_val = NO_DELAY;
        1: delay_val = $urandom_range(0, 1);
        default: delay_val = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 255)
                                                         : $urandom_range(0, 1);
      endcase
      if ($urandom_range(0, 9) == 0)
        ncaps = $urandom_range(0, active_limit() + 1);
      else
        ncaps = $urandom_range(1, (active_limit() < 6) ? active_limit() : 6);
      build_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), delay_val, ncaps);
      if (sel >= 95) begin
        rec_buf.delete();
        repeat ($urandom_range(1, 8)) rec_buf.push_back(8'($urandom_range(0, 255)));
      end else if (sel >= 85) begin
        while (rec_buf.size() > 1 && $urandom_range(0, 3) != 0) void'(rec_buf.pop_back());
      end else if (sel >= 70) begin
        rec_buf[$urandom_range(0, rec_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_record();
      nrec++;
    end
  endtask

  // Back-to-back records with no idling on either side.
  task automatic test_steady_stream();
    idle_enable = 1'b0;
    write_limit(hrp_pkg::CNT_W'(hrp_pkg::CAPS_MAX));
    repeat (3) begin
      build_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 1) ? NO_DELAY : int'($urandom_range(0, 1)),
                   $urandom_range(1, 4));
      send_record();
    end
  endtask

  initial begin
    limit_now = hrp_pkg::LIMIT_RESET;
    clear_record();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed_records();
    test_limit_extremes();
    test_random_records();
    test_steady_stream();
    idle_input();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
